// ===== rtl/core/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// rct_pkg
// Types and codes used by the route cache table.
// ----------------------------------------------------------------------------
package rct_pkg;

  // Operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_GWRD,
    ST_RESP
  } state_e;

  // One request item
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dest_ip;
    logic [31:0] gateway_ip;
  } in_t;

  // One result item
  typedef struct packed {
    logic        hit;
    logic [31:0] gateway_out;
    logic        status;
  } out_t;

endpackage

// ===== rtl/core/rct_ram.sv =====
// ----------------------------------------------------------------------------
// rct_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/route_cache_table.sv =====
// ----------------------------------------------------------------------------
// route_cache_table
// Exact-match table from IPv4 destination to gateway address.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i / in_stall_o with an in_t payload; results
//   leave on out_valid_o / out_stall_i with an out_t payload. Each request
//   yields exactly one result, in request order.
//   Destinations and gateways sit in two RAMs with registered reads. A
//   lookup or add scans the valid slots one per cycle; a flush or an unused
//   kind skips the scan, and a hit stops it early. A lookup hit then reads
//   the gateway RAM before the result is built. The scan over the dest RAM
//   port sets the throughput: one request is in work at a time.
//   An add of a new destination into a full table is dropped with status 1.
//   The result sits in an output register; a new request is taken while a
//   finished result still waits. If the receiver stalls, the result holds
//   and the next result waits in the sequencer until the register frees.
//   Reset empties the table (entry count zero); RAM contents stay undefined
//   and are never read before they are written.
// ----------------------------------------------------------------------------
module route_cache_table
  import rct_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] CountMax = CW'(ENTRIES);

  state_e          state_q, state_d;
  in_t             req_q, req_d;
  out_t            res_q, res_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   issue_q, issue_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   pend_idx_q, pend_idx_d;
  logic            out_valid_q;
  out_t            out_data_q;

  logic            in_xfer;
  logic            out_free;
  logic            match;

  logic            dst_we, dst_re;
  logic [AW-1:0]   dst_raddr;
  logic [31:0]     dst_rdata;
  logic            gw_we, gw_re;
  logic [AW-1:0]   gw_waddr;
  logic [31:0]     gw_wdata;
  logic [31:0]     gw_rdata;

  // Storage
  rct_ram #(.WIDTH(32), .DEPTH(ENTRIES), .AW(AW)) u_dest_ram (
    .clk_i   (clk_i),
    .we_i    (dst_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (req_q.dest_ip),
    .re_i    (dst_re),
    .raddr_i (dst_raddr),
    .rdata_o (dst_rdata)
  );

  rct_ram #(.WIDTH(32), .DEPTH(ENTRIES), .AW(AW)) u_gw_ram (
    .clk_i   (clk_i),
    .we_i    (gw_we),
    .waddr_i (gw_waddr),
    .wdata_i (gw_wdata),
    .re_i    (gw_re),
    .raddr_i (pend_idx_q),
    .rdata_o (gw_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign match      = pend_q && (dst_rdata == req_q.dest_ip);
  assign dst_raddr  = issue_q[AW-1:0];
  assign gw_wdata   = req_q.gateway_ip;

  // Sequencer: scan, update and build the result
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    res_d      = res_q;
    count_d    = count_q;
    issue_d    = issue_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    dst_we     = 1'b0;
    dst_re     = 1'b0;
    gw_we      = 1'b0;
    gw_re      = 1'b0;
    gw_waddr   = pend_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          req_d   = in_data_i;
          res_d   = '0;
          issue_d = '0;
          pend_d  = 1'b0;
          case (in_data_i.kind)
            KIND_LOOKUP, KIND_ADD: state_d = ST_SEARCH;
            KIND_FLUSH: begin
              count_d = '0;
              state_d = ST_RESP;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      ST_SEARCH: begin
        if (match) begin
          // Hit: read gateway for a lookup, overwrite it for an add
          if (req_q.kind == KIND_LOOKUP) begin
            gw_re   = 1'b1;
            state_d = ST_GWRD;
          end else begin
            gw_we     = 1'b1;
            res_d.hit = 1'b1;
            state_d   = ST_RESP;
          end
        end else if (issue_q >= count_q) begin
          // Miss: an add appends a new route, or is dropped when full
          if (req_q.kind == KIND_ADD) begin
            if (count_q < CountMax) begin
              dst_we   = 1'b1;
              gw_we    = 1'b1;
              gw_waddr = count_q[AW-1:0];
              count_d  = count_q + 1'b1;
            end else begin
              res_d.status = 1'b1;
            end
          end
          state_d = ST_RESP;
        end else begin
          // Advance the scan by one slot
          dst_re     = 1'b1;
          issue_d    = issue_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = issue_q[AW-1:0];
        end
      end

      ST_GWRD: begin
        res_d.hit         = 1'b1;
        res_d.gateway_out = gw_rdata;
        state_d           = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      issue_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      issue_q <= issue_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    pend_idx_q <= pend_idx_d;
  end

  // Output register: load a finished result, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP && out_free) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
